// ----- src/ntc_adc_to_temperature_defines.svh -----
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_defines
// Assertion macros shared by the thermistor conversion RTL.
// ----------------------------------------------------------------------------
`ifndef NTC_ADC_TO_TEMPERATURE_DEFINES_SVH
`define NTC_ADC_TO_TEMPERATURE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define NTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// ntc_pkg
// Types and constants of the thermistor ADC to temperature converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ntc_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int SERIES_W     = 20;
    localparam int NOM_W        = 20;
    localparam int BETA_W       = 16;
    localparam int T0_W         = 16;
    localparam int GUARD_W      = 11;
    localparam int LIM_W        = 17;
    localparam int TEMP_W       = 18;
    localparam int CFG_W        = 20;
    localparam int CFG_ADDR_W   = 3;

    // Log2 with 32 fraction bits; the integer part covers operands up to 64 bits.
    localparam int MANT_W    = 32;
    localparam int FRAC_W    = 32;
    localparam int TOP_W     = 6;
    localparam int LOG_W     = TOP_W + FRAC_W;
    localparam int LOG_STEPS = FRAC_W;

    localparam int LMAG_W = 39;
    localparam int BASE_W = 55;
    localparam int PROD_W = 55;
    localparam int DEN_W  = 56;
    localparam int N0_W   = 39;
    localparam int QUO_W  = 54;
    localparam int QFRAC_W = 33;
    localparam int DIV_LOW = QUO_W - QFRAC_W;
    localparam int C_W    = QUO_W + 1;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [14:0] KELVIN_OFS = 15'd27315;
    localparam logic signed [TEMP_W-1:0] FAULT_TEMP = -18'sd99900;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SERIES = 3'd0,
        CFG_NOMINAL = 3'd1,
        CFG_BETA = 3'd2,
        CFG_T0 = 3'd3,
        CFG_GUARD = 3'd4,
        CFG_MIN = 3'd5,
        CFG_MAX = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic fault;
    } t_ctl;

endpackage

`default_nettype wire

// ----- src/ntc_adc_to_temperature.sv -----
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// Converts a divider ADC code to hundredths of a degree Celsius with the
// thermistor beta equation, in a fixed-point pipeline.
// ----------------------------------------------------------------------------
//  channel     | direction | content
//  s_axis      | in        | tdata: adc_sample
//  m_axis      | out       | tdata: temp_centi_c; tuser: fault
//  cfg         | in        | write enable, register index, data
//
// One beat per cycle unless the output is held. There are 98 register stages,
// from the 32 log2 squaring steps and the 54 subtract steps of the quotient.
// Reset clears the valid bits and loads the register defaults.
// When the output beat is held, the whole pipeline freezes; nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ntc_adc_to_temperature_defines.svh"

module ntc_adc_to_temperature
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire  [((ADC_BITS+7)/8)*8-1:0]   i_s_axis_tdata,  // [ADC_BITS-1:0] adc_sample
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    output logic [((TEMP_W+7)/8)*8-1:0]     o_m_axis_tdata,  // [17:0] temp_centi_c
    output logic [0:0]                      o_m_axis_tuser,  // [0] fault
    input  wire                             i_cfg_we,
    input  wire  [CFG_ADDR_W-1:0]           i_cfg_addr,
    input  wire  [CFG_W-1:0]                i_cfg_wdata
);

    localparam int OUT_W = ((TEMP_W + 7) / 8) * 8;
    localparam int X_W   = SERIES_W + ADC_BITS;
    localparam int CMP_W = 18;
    localparam int SV_W  = ADC_BITS + 9;
    localparam logic [ADC_BITS-1:0] ADC_TOP = '1;

    // Configuration registers and values derived from them.
    logic [SERIES_W-1:0] r_series;
    logic [NOM_W-1:0]    r_nominal;
    logic [BETA_W-1:0]   r_beta;
    logic [T0_W-1:0]     r_t0;
    logic [GUARD_W-1:0]  r_guard;
    logic [LIM_W-1:0]    r_min;
    logic [LIM_W-1:0]    r_max;
    logic [BASE_W-1:0]   r_base;
    logic [22:0]         r_t100;
    logic [N0_W-1:0]     r_n0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series  <= SERIES_W'(10000);
            r_nominal <= NOM_W'(10000);
            r_beta    <= BETA_W'(3950);
            r_t0      <= T0_W'(29815);
            r_guard   <= GUARD_W'(16);
            r_min     <= LIM_W'(-1000);
            r_max     <= LIM_W'(15000);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SERIES:  r_series  <= i_cfg_wdata[SERIES_W-1:0];
                CFG_NOMINAL: r_nominal <= i_cfg_wdata[NOM_W-1:0];
                CFG_BETA:    r_beta    <= i_cfg_wdata[BETA_W-1:0];
                CFG_T0:      r_t0      <= i_cfg_wdata[T0_W-1:0];
                CFG_GUARD:   r_guard   <= i_cfg_wdata[GUARD_W-1:0];
                CFG_MIN:     r_min     <= i_cfg_wdata[LIM_W-1:0];
                CFG_MAX:     r_max     <= i_cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= {23'(r_beta) * 23'd100, 32'd0};
        r_t100 <= 23'(r_t0) * 23'd100;
        r_n0   <= N0_W'(r_t100) * N0_W'(r_beta);
    end

    logic ce;
    logic r_out_valid;
    assign ce = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    // Stage 0: input register.
    t_ctl                r_s0_ctl;
    logic [ADC_BITS-1:0] r_s0_adc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
        end else if (ce) begin
            r_s0_ctl.valid <= i_s_axis_tvalid;
            r_s0_ctl.fault <= 1'b0;
            r_s0_adc       <= i_s_axis_tdata[ADC_BITS-1:0];
        end
    end

    // Stage 1: sample checks, numerator and denominator of R/R0.
    t_ctl           r_s1_ctl;
    logic [X_W-1:0] r_s1_x [0:1];
    logic           n_s1_fault;

    always_comb begin
        n_s1_fault = (CMP_W'(r_s0_adc) < CMP_W'(r_guard))
                  || (CMP_W'(r_s0_adc) + CMP_W'(r_guard) > CMP_W'(ADC_TOP))
                  || (SV_W'(ADC_TOP - r_s0_adc) * SV_W'(330) < SV_W'(ADC_TOP))
                  || (r_s0_adc == '0) || (r_series == '0) || (r_nominal == '0)
                  || (r_beta == '0) || (r_t0 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (ce) begin
            r_s1_ctl.valid <= r_s0_ctl.valid;
            r_s1_ctl.fault <= n_s1_fault;
            r_s1_x[0]      <= X_W'(r_series) * X_W'(r_s0_adc);
            r_s1_x[1]      <= X_W'(ADC_TOP - r_s0_adc) * X_W'(r_nominal);
        end
    end

    // Stage 2: position of the leading one.
    t_ctl             r_s2_ctl;
    logic [X_W-1:0]   r_s2_x   [0:1];
    logic [TOP_W-1:0] r_s2_top [0:1];
    logic [TOP_W-1:0] n_s2_top [0:1];

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            n_s2_top[h] = '0;
            for (int i = 0; i < X_W; i++) begin
                if (r_s1_x[h][i]) begin
                    n_s2_top[h] = TOP_W'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (ce) begin
            r_s2_ctl    <= r_s1_ctl;
            r_s2_x      <= r_s1_x;
            r_s2_top[0] <= n_s2_top[0];
            r_s2_top[1] <= n_s2_top[1];
        end
    end

    // Stage 3 and the squaring chain: mantissa normalized to [1, 2) in Q1.31.
    t_ctl              r_lg_ctl [0:LOG_STEPS];
    logic [MANT_W-1:0] r_lg_m   [0:LOG_STEPS][0:1];
    logic [FRAC_W-1:0] r_lg_f   [0:LOG_STEPS][0:1];
    logic [TOP_W-1:0]  r_lg_top [0:LOG_STEPS][0:1];
    logic [X_W+MANT_W-1:0] n_norm [0:1];

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            n_norm[h] = {r_s2_x[h], MANT_W'(0)} << (TOP_W'(X_W - 1) - r_s2_top[h]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_ctl[0] <= '0;
        end else if (ce) begin
            r_lg_ctl[0] <= r_s2_ctl;
            for (int h = 0; h < 2; h++) begin
                r_lg_m[0][h]   <= n_norm[h][X_W+MANT_W-1 -: MANT_W];
                r_lg_f[0][h]   <= '0;
                r_lg_top[0][h] <= r_s2_top[h];
            end
        end
    end

    // Each step squares the mantissa; a carry into bit 32 is the next fraction bit.
    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
        for (genvar h = 0; h < 2; h++) begin : g_ch
            logic [2*MANT_W-1:0] n_sq;
            assign n_sq = (2*MANT_W)'(r_lg_m[g][h]) * (2*MANT_W)'(r_lg_m[g][h]);

            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_lg_m[g+1][h]   <= n_sq[2*MANT_W-1] ? n_sq[2*MANT_W-1:MANT_W]
                                                         : n_sq[2*MANT_W-2:MANT_W-1];
                    r_lg_f[g+1][h]   <= {r_lg_f[g][h][FRAC_W-2:0], n_sq[2*MANT_W-1]};
                    r_lg_top[g+1][h] <= r_lg_top[g][h];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lg_ctl[g+1] <= '0;
            end else if (ce) begin
                r_lg_ctl[g+1] <= r_lg_ctl[g];
            end
        end
    end

    // Stage 4: log2 difference as sign and magnitude.
    t_ctl             r_s4_ctl;
    logic             r_s4_neg;
    logic [LOG_W-1:0] r_s4_mag;
    logic [LOG_W-1:0] n_lgn;
    logic [LOG_W-1:0] n_lgd;

    assign n_lgn = {r_lg_top[LOG_STEPS][0], r_lg_f[LOG_STEPS][0]};
    assign n_lgd = {r_lg_top[LOG_STEPS][1], r_lg_f[LOG_STEPS][1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
        end else if (ce) begin
            r_s4_ctl <= r_lg_ctl[LOG_STEPS];
            r_s4_neg <= n_lgn < n_lgd;
            r_s4_mag <= (n_lgn < n_lgd) ? (n_lgd - n_lgn) : (n_lgn - n_lgd);
        end
    end

    // Stage 5: the two halves of the multiplication by ln2.
    t_ctl        r_s5_ctl;
    logic        r_s5_neg;
    logic [53:0] r_s5_pa;
    logic [47:0] r_s5_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_ctl <= '0;
        end else if (ce) begin
            r_s5_ctl <= r_s4_ctl;
            r_s5_neg <= r_s4_neg;
            r_s5_pa  <= 54'(r_s4_mag[LOG_W-1:16]) * 54'(LN2_Q32);
            r_s5_pb  <= 48'(r_s4_mag[15:0]) * 48'(LN2_Q32);
        end
    end

    // Stage 6: ln magnitude, rounded to 32 fraction bits.
    t_ctl              r_s6_ctl;
    logic              r_s6_neg;
    logic [LMAG_W-1:0] r_s6_lmag;
    logic [LMAG_W+15:0] n_lsum;

    assign n_lsum = (LMAG_W+16)'(r_s5_pa) + (LMAG_W+16)'(r_s5_pb[47:16])
                  + (LMAG_W+16)'(17'h08000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_ctl <= '0;
        end else if (ce) begin
            r_s6_ctl  <= r_s5_ctl;
            r_s6_neg  <= r_s5_neg;
            r_s6_lmag <= n_lsum[LMAG_W+15:16];
        end
    end

    // Stage 7: ln(R/R0) times the nominal temperature.
    t_ctl              r_s7_ctl;
    logic              r_s7_neg;
    logic [PROD_W-1:0] r_s7_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_ctl <= '0;
        end else if (ce) begin
            r_s7_ctl  <= r_s6_ctl;
            r_s7_neg  <= r_s6_neg;
            r_s7_prod <= PROD_W'(r_s6_lmag) * PROD_W'(r_t0);
        end
    end

    // Stage 8: divisor; a non-positive reciprocal temperature is a fault.
    t_ctl             r_s8_ctl;
    logic [DEN_W-1:0] r_s8_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_ctl <= '0;
        end else if (ce) begin
            r_s8_ctl.valid <= r_s7_ctl.valid;
            r_s8_ctl.fault <= r_s7_ctl.fault || (r_s7_neg && (r_s7_prod >= r_base));
            r_s8_den       <= r_s7_neg ? (DEN_W'(r_base) - DEN_W'(r_s7_prod))
                                       : (DEN_W'(r_base) + DEN_W'(r_s7_prod));
        end
    end

    // Division: integer part above 2^20 is a fault, else 54 restoring steps
    // give the quotient with 33 fraction bits.
    t_ctl             r_dv_ctl [0:QUO_W];
    logic [DEN_W-1:0] r_dv_rem [0:QUO_W];
    logic [DEN_W-1:0] r_dv_den [0:QUO_W];
    logic [QUO_W-1:0] r_dv_q   [0:QUO_W];
    logic             n_ovf;

    assign n_ovf = (DEN_W+21)'(r_n0) >= ({r_s8_den, 20'd0} + (DEN_W+21)'(r_s8_den));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_ctl[0] <= '0;
        end else if (ce) begin
            r_dv_ctl[0].valid <= r_s8_ctl.valid;
            r_dv_ctl[0].fault <= r_s8_ctl.fault || n_ovf;
            r_dv_rem[0]       <= DEN_W'(r_n0[N0_W-1:DIV_LOW]);
            r_dv_den[0]       <= r_s8_den;
            r_dv_q[0]         <= '0;
        end
    end

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        logic         n_bit;
        logic [DEN_W:0] n_sh;
        logic         n_ge;

        if (g < DIV_LOW) begin : g_nbit
            assign n_bit = r_n0[DIV_LOW-1-g];
        end else begin : g_zbit
            assign n_bit = 1'b0;
        end

        assign n_sh = {r_dv_rem[g], n_bit};
        assign n_ge = n_sh >= {1'b0, r_dv_den[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_ctl[g+1] <= '0;
            end else if (ce) begin
                r_dv_ctl[g+1] <= r_dv_ctl[g];
                r_dv_rem[g+1] <= n_ge ? DEN_W'(n_sh - {1'b0, r_dv_den[g]})
                                      : DEN_W'(n_sh);
                r_dv_den[g+1] <= r_dv_den[g];
                r_dv_q[g+1]   <= {r_dv_q[g][QUO_W-2:0], n_ge};
            end
        end
    end

    // Stage 10: round half up to 0.01 K and move to Celsius.
    t_ctl                  r_s10_ctl;
    logic signed [C_W-1:0] r_s10_c;
    logic [QUO_W:0]        n_rnd;

    assign n_rnd = (QUO_W+1)'(r_dv_q[QUO_W]) + (QUO_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_ctl <= '0;
        end else if (ce) begin
            r_s10_ctl <= r_dv_ctl[QUO_W];
            r_s10_c   <= $signed({1'b0, n_rnd[QUO_W:1]}) - $signed(C_W'(KELVIN_OFS));
        end
    end

    // Output stage: plausibility window and fault substitution.
    logic signed [C_W-1:0]    n_min;
    logic signed [C_W-1:0]    n_max;
    logic                     n_fault;
    logic                     r_out_fault;
    logic signed [TEMP_W-1:0] r_out_temp;

    assign n_min   = C_W'($signed(r_min));
    assign n_max   = C_W'($signed(r_max));
    assign n_fault = r_s10_ctl.fault || (r_s10_c < n_min) || (r_s10_c > n_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= r_s10_ctl.valid;
            r_out_fault <= n_fault;
            r_out_temp  <= n_fault ? FAULT_TEMP : r_s10_c[TEMP_W-1:0];
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = OUT_W'(unsigned'(r_out_temp));
    assign o_m_axis_tuser[0] = r_out_fault;

    `NTC_ASSERT_NOW(a_ready_when_empty, !o_m_axis_tvalid, o_s_axis_tready,
        "input stalled with empty output")
    `NTC_ASSERT_NOW(a_fault_value, o_m_axis_tvalid && o_m_axis_tuser[0],
        $signed(o_m_axis_tdata[TEMP_W-1:0]) == FAULT_TEMP,
        "fault beat without fault temperature")
    `NTC_ASSERT_NOW(a_in_window, o_m_axis_tvalid && !o_m_axis_tuser[0],
        ($signed(o_m_axis_tdata[TEMP_W-1:0]) >= $signed(r_min))
        && ($signed(o_m_axis_tdata[TEMP_W-1:0]) <= $signed(r_max)),
        "good beat outside plausible window")
    `NTC_ASSERT_NEXT(a_drain, o_m_axis_tvalid && i_m_axis_tready && !r_s10_ctl.valid,
        !o_m_axis_tvalid, "output beat repeated")

endmodule

`default_nettype wire
